/* src/cats_pkg.sv */
// Shared types and constants for the comment-aware token splitter.
// No dependencies; used by cats_step, cats_outbuf and the top level.
package cats_pkg;

  localparam int unsigned TokenMaxDef = 256;
  localparam int unsigned NumSpace    = 4;

  localparam logic [7:0] NewlineChar = 8'd10;

  // Configuration register indexes
  localparam logic [2:0] CfgSpace0   = 3'd0;
  localparam logic [2:0] CfgSpace1   = 3'd1;
  localparam logic [2:0] CfgSpace2   = 3'd2;
  localparam logic [2:0] CfgSpace3   = 3'd3;
  localparam logic [2:0] CfgSpaceCnt = 3'd4;
  localparam logic [2:0] CfgComment  = 3'd5;

  typedef struct packed {
    logic [NumSpace-1:0][7:0] space_char;
    logic [2:0]               space_count;
    logic [7:0]               comment_char;
  } cfg_t;

  typedef struct packed {
    logic in_token;
    logic in_comment;
  } flags_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       out_eof;
    logic       token_last;
    logic       overflow;
  } result_t;

endpackage

/* src/cats_step.sv */
// Per-character decision logic: classifies one character and computes the next
// splitter state and the optional result beat. Depends on cats_pkg.
module cats_step #(
  parameter int unsigned TOKEN_MAX = cats_pkg::TokenMaxDef,
  localparam int unsigned LenW     = $clog2(TOKEN_MAX + 1)
) (
  input  cats_pkg::cfg_t    cfg_i,
  input  logic [7:0]        in_char_i,
  input  logic              at_eof_i,
  input  cats_pkg::flags_t  flags_i,
  input  logic [LenW-1:0]   len_i,
  output cats_pkg::flags_t  flags_o,
  output logic [LenW-1:0]   len_o,
  output logic              res_valid_o,
  output cats_pkg::result_t res_o
);

  logic [2:0] n_used;
  logic       is_sep;
  logic       is_nl;

  assign n_used = (cfg_i.space_count > 3'd4) ? 3'd4 : cfg_i.space_count;
  assign is_nl  = (in_char_i == cats_pkg::NewlineChar);

  always_comb begin
    is_sep = 1'b0;
    for (int i = 0; i < cats_pkg::NumSpace; i++) begin
      if ((3'(i) < n_used) && (cfg_i.space_char[i] == in_char_i)) begin
        is_sep = 1'b1;
      end
    end
  end

  always_comb begin
    flags_o     = flags_i;
    len_o       = len_i;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (at_eof_i) begin
      flags_o          = '0;
      len_o            = '0;
      res_valid_o      = 1'b1;
      res_o.out_eof    = 1'b1;
      res_o.token_last = 1'b1;
    end else if (flags_i.in_comment) begin
      // drop everything but the newline that ends the comment
      if (is_nl) begin
        flags_o          = '0;
        len_o            = '0;
        res_valid_o      = 1'b1;
        res_o.out_char   = in_char_i;
        res_o.token_last = 1'b1;
      end
    end else if (in_char_i == cfg_i.comment_char) begin
      flags_o.in_comment = 1'b1;
    end else if (is_sep) begin
      if (flags_i.in_token || is_nl) begin
        flags_o          = '0;
        len_o            = '0;
        res_valid_o      = 1'b1;
        res_o.out_char   = in_char_i;
        res_o.token_last = 1'b1;
      end
    end else if (len_i >= LenW'(TOKEN_MAX)) begin
      flags_o          = '0;
      len_o            = '0;
      res_valid_o      = 1'b1;
      res_o.token_last = 1'b1;
      res_o.overflow   = 1'b1;
    end else begin
      flags_o.in_token = 1'b1;
      len_o            = len_i + LenW'(1);
      res_valid_o      = 1'b1;
      res_o.out_char   = in_char_i;
    end
  end

endmodule

/* src/cats_outbuf.sv */
// Result register with valid/ready toward the consumer.
// Depends on cats_pkg for the result beat type.
module cats_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  cats_pkg::result_t res_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cats_pkg::result_t res_o
);

  logic              vld_q;
  cats_pkg::result_t res_q;

  // free when empty or the held beat leaves this cycle
  assign ready_o     = !vld_q || out_ready_i;
  assign out_valid_o = vld_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      res_q <= res_i;
    end
  end

endmodule

/* src/comment_aware_token_splitter.sv */
// Top level of the comment-aware token splitter: input register, config
// registers, splitter state. Depends on cats_pkg, cats_step, cats_outbuf.
//
// Accepts one character (or end-of-file mark) per cycle and produces at most
// one result beat per character. An accepted character is held in the input
// register; its result is then loaded into the result register, which presents
// it on the output and holds it until the consumer takes it. Throughput is one
// item per cycle and is only reduced by the consumer holding out_ready_i low,
// which stalls both stages. Config writes take effect at once and are always
// accepted; write them only while idle.
module comment_aware_token_splitter #(
  parameter int unsigned TOKEN_MAX = cats_pkg::TokenMaxDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       at_eof_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       out_eof_o,
  output logic       token_last_o,
  output logic       overflow_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  localparam int unsigned LenW = $clog2(TOKEN_MAX + 1);

  cats_pkg::cfg_t    cfg_q;
  logic              in_vld_q;
  logic [7:0]        in_char_q;
  logic              in_eof_q;
  cats_pkg::flags_t  flags_q, flags_d;
  logic [LenW-1:0]   len_q, len_d;
  logic              res_valid;
  cats_pkg::result_t res, res_out;
  logic              adv;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.space_char[0] <= 8'd32;
      cfg_q.space_char[1] <= 8'd9;
      cfg_q.space_char[2] <= 8'd10;
      cfg_q.space_char[3] <= 8'd13;
      cfg_q.space_count   <= 3'd4;
      cfg_q.comment_char  <= 8'd35;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cats_pkg::CfgSpace0:   cfg_q.space_char[0] <= cfg_data_i;
        cats_pkg::CfgSpace1:   cfg_q.space_char[1] <= cfg_data_i;
        cats_pkg::CfgSpace2:   cfg_q.space_char[2] <= cfg_data_i;
        cats_pkg::CfgSpace3:   cfg_q.space_char[3] <= cfg_data_i;
        cats_pkg::CfgSpaceCnt: cfg_q.space_count   <= cfg_data_i[2:0];
        cats_pkg::CfgComment:  cfg_q.comment_char  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_char_q <= in_char_i;
      in_eof_q  <= at_eof_i;
    end
  end

  cats_step #(
    .TOKEN_MAX (TOKEN_MAX)
  ) u_step (
    .cfg_i       (cfg_q),
    .in_char_i   (in_char_q),
    .at_eof_i    (in_eof_q),
    .flags_i     (flags_q),
    .len_i       (len_q),
    .flags_o     (flags_d),
    .len_o       (len_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // state advances only when the held character leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      len_q   <= '0;
    end else if (in_vld_q && adv) begin
      flags_q <= flags_d;
      len_q   <= len_d;
    end
  end

  cats_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_vld_q && res_valid),
    .res_i       (res),
    .ready_o     (adv),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_out)
  );

  assign out_char_o   = res_out.out_char;
  assign out_eof_o    = res_out.out_eof;
  assign token_last_o = res_out.token_last;
  assign overflow_o   = res_out.overflow;

endmodule

/* src/cats_checker.sv */
// Port-level checks for the comment-aware token splitter, bound to the top.
// Depends on comment_aware_token_splitter.
module cats_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_char_o,
  input logic       out_eof_o,
  input logic       token_last_o,
  input logic       overflow_o
);

  // end-of-file beat carries no character and closes the token
  a_eof_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_eof_o |-> token_last_o && !overflow_o && (out_char_o == 8'd0))
    else $error("eof beat malformed");

  a_ovf_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> token_last_o && !out_eof_o && (out_char_o == 8'd0))
    else $error("overflow beat malformed");

  // input backpressure only comes from a stalled result
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output stall");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_char_o)
      && $stable(token_last_o))
    else $error("result beat changed while stalled");

endmodule

bind comment_aware_token_splitter cats_checker u_cats_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_char_o   (out_char_o),
  .out_eof_o    (out_eof_o),
  .token_last_o (token_last_o),
  .overflow_o   (overflow_o)
);
